// File: hdl/lkvt_pkg.sv
package lkvt_pkg;

    // table geometry
    localparam int CAPACITY    = 256;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int MODE_W      = 3;
    localparam int LIMIT_W     = 9;

    localparam logic [CNT_W-1:0] CAPACITY_CNT  = CNT_W'(CAPACITY);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UPSERT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOKUP     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_INDEX = 3'd5;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_MISS,
        ST_RDIDX,
        ST_POST
    } state_t;

    // write request into the entry store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } mem_wr_t;

endpackage

// File: hdl/lkvt_in_if.sv
interface lkvt_in_if
    import lkvt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [ADDR_W-1:0] index;

    modport source (output valid, output mode, output key, output value, output index,
                    input ready);
    modport sink   (input valid, input mode, input key, input value, input index,
                    output ready);
endinterface

// File: hdl/lkvt_out_if.sv
interface lkvt_out_if
    import lkvt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [KEY_W-1:0] key_out;
    logic [VAL_W-1:0] value_out;
    logic [CNT_W-1:0] count;

    modport source (output valid, output ok, output key_out, output value_out,
                    output count, input ready);
    modport sink   (input valid, input ok, input key_out, input value_out,
                    input count, output ready);
endinterface

// File: hdl/linear_key_value_table.sv
// Linear key/value table: up to 256 entries held packed at positions 0..count-1
// and searched from position 0 upward, one entry per cycle through a single
// registered read port of the entry store.
// in_ch carries one word per operation (mode, key, value, index); out_ch returns
// one word per operation (ok, key_out, value_out, count after the operation).
// Both are valid/ready channels; a word moves when valid and ready are high.
// in_ch.ready is high only while the sequencer is idle: one operation at a time.
// Per operation, with the match at position p: a hit at p stops the scan; a miss
// (insert, failed update/lookup/erase) scans all count entries, then appends the
// key for insert or insert-or-update if there is room; an erase hit then moves the
// entries above p down by one, one entry a cycle; read by index reads the store
// once; an unused mode or an index out of range goes straight to the result.
// in_ch.ready rises again in the cycle after the result is registered.
// The result sits in an output register; a stalled receiver holds the finished
// result there and the next operation can be accepted and run meanwhile.
// cfg_we/cfg_wdata write the capacity limit (clamped to 256); the user must write
// it only while idle, the block itself does not enforce this. Reset (rst_n low,
// asynchronous) empties the table and sets the limit to 256; store contents are
// not cleared, only entries below count ever reach a result.
module linear_key_value_table
    import lkvt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    lkvt_in_if.sink            in_ch,
    lkvt_out_if.source         out_ch
);

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic [ADDR_W-1:0] p_reg, p_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic              res_ok_reg, res_ok_next;
    logic [KEY_W-1:0]  res_key_reg, res_key_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic [KEY_W-1:0]  rd_key;
    logic [VAL_W-1:0]  rd_value;
    mem_wr_t           wr;

    logic              accept;
    logic              out_free;
    logic              hit;
    logic              last_scan;
    logic              shift_last;
    logic              table_full;
    logic              is_key_op;
    logic [CNT_W-1:0]  p_ext;
    logic [CNT_W-1:0]  limit_eff;

    // entry store
    lkvt_mem u_mem (
        .clk      (clk),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    // handshake and compare terms
    assign accept     = in_ch.valid && in_ch.ready;
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign hit        = (rd_key == key_reg);
    assign p_ext      = {1'b0, p_reg};
    assign last_scan  = ((p_ext + CNT_W'(1)) == count_reg);
    assign shift_last = ((p_ext + CNT_W'(2)) == count_reg);
    assign limit_eff  = (limit_reg > LIMIT_W'(CAPACITY)) ? CAPACITY_CNT
                                                        : CNT_W'(limit_reg);
    assign table_full = (count_reg >= limit_eff);
    assign is_key_op  = (in_ch.mode == MODE_INSERT) || (in_ch.mode == MODE_UPDATE)
                     || (in_ch.mode == MODE_UPSERT) || (in_ch.mode == MODE_ERASE)
                     || (in_ch.mode == MODE_LOOKUP);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_key_op)
                    begin
                        state_next = (count_reg == '0) ? ST_MISS : ST_SCAN;
                    end
                    else if (in_ch.mode == MODE_READ_INDEX)
                    begin
                        state_next = ({1'b0, in_ch.index} < count_reg) ? ST_RDIDX
                                                                       : ST_POST;
                    end
                    else
                    begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = (mode_reg == MODE_ERASE && !last_scan) ? ST_SHIFT
                                                                        : ST_POST;
                end
                else if (last_scan)
                begin
                    state_next = ST_MISS;
                end
            end
            ST_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = ST_POST;
                end
            end
            ST_MISS:  state_next = ST_POST;
            ST_RDIDX: state_next = ST_POST;
            ST_POST:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and datapath
    always_comb
    begin
        in_ch.ready    = 1'b0;
        rd_addr        = p_reg + ADDR_W'(1);
        wr             = '0;
        mode_next      = mode_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        p_next         = p_reg;
        count_next     = count_reg;
        res_ok_next    = res_ok_reg;
        res_key_next   = res_key_reg;
        res_value_next = res_value_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                rd_addr     = (in_ch.mode == MODE_READ_INDEX) ? in_ch.index : '0;
                if (accept)
                begin
                    mode_next      = in_ch.mode;
                    key_next       = in_ch.key;
                    value_next     = in_ch.value;
                    p_next         = '0;
                    res_ok_next    = 1'b0;
                    res_key_next   = '0;
                    res_value_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    if (mode_reg == MODE_UPDATE || mode_reg == MODE_UPSERT)
                    begin
                        wr.en       = 1'b1;
                        wr.addr     = p_reg;
                        wr.key      = key_reg;
                        wr.value    = value_reg;
                        res_ok_next = 1'b1;
                    end
                    else if (mode_reg == MODE_ERASE)
                    begin
                        res_ok_next = 1'b1;
                        if (last_scan)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    else if (mode_reg == MODE_LOOKUP)
                    begin
                        res_ok_next    = 1'b1;
                        res_key_next   = rd_key;
                        res_value_next = rd_value;
                    end
                end
                else if (!last_scan)
                begin
                    p_next = p_reg + ADDR_W'(1);
                end
            end
            ST_SHIFT:
            begin
                // entry p+1 is on the read port: move it down to p
                rd_addr  = p_reg + ADDR_W'(2);
                wr.en    = 1'b1;
                wr.addr  = p_reg;
                wr.key   = rd_key;
                wr.value = rd_value;
                if (shift_last)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    p_next = p_reg + ADDR_W'(1);
                end
            end
            ST_MISS:
            begin
                // append at the end when the key is new and there is room
                if ((mode_reg == MODE_INSERT || mode_reg == MODE_UPSERT) && !table_full)
                begin
                    wr.en       = 1'b1;
                    wr.addr     = count_reg[ADDR_W-1:0];
                    wr.key      = key_reg;
                    wr.value    = value_reg;
                    count_next  = count_reg + CNT_W'(1);
                    res_ok_next = 1'b1;
                end
            end
            ST_RDIDX:
            begin
                res_ok_next    = 1'b1;
                res_key_next   = rd_key;
                res_value_next = rd_value;
            end
            ST_POST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // operation and result payload
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        value_reg     <= value_next;
        p_reg         <= p_next;
        res_ok_reg    <= res_ok_next;
        res_key_reg   <= res_key_next;
        res_value_reg <= res_value_next;
        if (state_reg == ST_POST && out_free)
        begin
            out_ok_reg    <= res_ok_reg;
            out_key_reg   <= res_key_reg;
            out_value_reg <= res_value_reg;
            out_count_reg <= count_reg;
        end
    end

    // output word
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.ok        = out_ok_reg;
    assign out_ch.key_out   = out_key_reg;
    assign out_ch.value_out = out_value_reg;
    assign out_ch.count     = out_count_reg;

endmodule

// File: hdl/lkvt_mem.sv
module lkvt_mem
    import lkvt_pkg::*;
(
    input  logic              clk,
    input  mem_wr_t           wr,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [KEY_W-1:0]  rd_key,
    output logic [VAL_W-1:0]  rd_value
);

    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [VAL_W-1:0] val_mem [CAPACITY];
    logic [KEY_W-1:0] rd_key_reg;
    logic [VAL_W-1:0] rd_value_reg;

    // one write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            key_mem[wr.addr] <= wr.key;
            val_mem[wr.addr] <= wr.value;
        end
    end

    // one registered read port
    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= val_mem[rd_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

// File: tb/sv/tb_linear_key_value_table.sv
`timescale 1ns / 1ps

module tb_linear_key_value_table;
    import lkvt_pkg::*;

    // mode codes the block ignores
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam int MAX_WAIT   = 12;
    localparam int HOLD_START = 300;
    localparam int HOLD_LEN   = 600;
    localparam int DRAIN_WAIT = 2 * CAPACITY + 64;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [ADDR_W-1:0] index;
    } table_op_t;

    typedef struct {
        logic             ok;
        logic [KEY_W-1:0] key_out;
        logic [VAL_W-1:0] value_out;
        logic [CNT_W-1:0] count;
    } table_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;

    lkvt_in_if  op_ch ();
    lkvt_out_if res_ch ();

    linear_key_value_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (op_ch),
        .out_ch    (res_ch)
    );

    // shadow copy of the table
    logic [KEY_W-1:0]   model_keys   [CAPACITY];
    logic [VAL_W-1:0]   model_values [CAPACITY];
    int                 model_count = 0;
    logic [LIMIT_W-1:0] model_limit = LIMIT_RESET;

    table_op_t     op_queue[$];
    table_result_t pending_results[$];
    logic [KEY_W-1:0] key_pool[$];

    logic op_taken     = 1'b0;
    logic result_taken = 1'b0;
    logic hold_off;
    logic send_calm    = 1'b0;
    logic recv_calm    = 1'b0;
    int   send_wait    = 0;
    int   recv_wait    = 0;
    int   words_taken  = 0;
    int   words_checked = 0;
    int   mismatch_count = 0;
    int   peak_entries = 0;
    int   limit_writes = 0;
    int   ops_by_mode[8];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // apply one operation to the shadow table and return the word it should produce
    function automatic table_result_t apply_table_op(input table_op_t op);
        table_result_t res;
        int            pos;
        int            lim;
        logic          full;
        res.ok        = 1'b0;
        res.key_out   = '0;
        res.value_out = '0;
        pos = model_count;
        for (int i = model_count - 1; i >= 0; i--)
            if (model_keys[i] == op.key)
                pos = i;
        lim  = (int'(model_limit) > CAPACITY) ? CAPACITY : int'(model_limit);
        full = (model_count >= lim);
        case (op.mode)
            MODE_INSERT, MODE_UPSERT:
            begin
                if (pos < model_count && op.mode == MODE_UPSERT)
                begin
                    model_values[pos] = op.value;
                    res.ok = 1'b1;
                end
                else if (pos == model_count && !full)
                begin
                    model_keys[model_count]   = op.key;
                    model_values[model_count] = op.value;
                    model_count++;
                    res.ok = 1'b1;
                end
            end
            MODE_UPDATE:
            begin
                if (pos < model_count)
                begin
                    model_values[pos] = op.value;
                    res.ok = 1'b1;
                end
            end
            MODE_ERASE:
            begin
                if (pos < model_count)
                begin
                    for (int j = pos; j + 1 < model_count; j++)
                    begin
                        model_keys[j]   = model_keys[j + 1];
                        model_values[j] = model_values[j + 1];
                    end
                    model_count--;
                    res.ok = 1'b1;
                end
            end
            MODE_LOOKUP:
            begin
                if (pos < model_count)
                begin
                    res.key_out   = model_keys[pos];
                    res.value_out = model_values[pos];
                    res.ok        = 1'b1;
                end
            end
            MODE_READ_INDEX:
            begin
                if (int'(op.index) < model_count)
                begin
                    res.key_out   = model_keys[op.index];
                    res.value_out = model_values[op.index];
                    res.ok        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (model_count > peak_entries)
            peak_entries = model_count;
        res.count = CNT_W'(model_count);
        return res;
    endfunction

    // sample both channels and the register port
    always @(posedge clk)
    begin
        table_op_t     seen;
        table_result_t want;
        if (rst_n)
        begin
            if (cfg_we)
                model_limit = cfg_wdata;
            op_taken     <= op_ch.valid && op_ch.ready;
            result_taken <= res_ch.valid && res_ch.ready;
            if (op_ch.valid && op_ch.ready)
            begin
                seen.mode  = op_ch.mode;
                seen.key   = op_ch.key;
                seen.value = op_ch.value;
                seen.index = op_ch.index;
                pending_results.push_back(apply_table_op(seen));
                ops_by_mode[op_ch.mode]++;
                words_taken++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing pending: ok=%0b count=%0d",
                           res_ch.ok, res_ch.count);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    words_checked++;
                    if (res_ch.ok !== want.ok)
                    begin
                        $error("ok: expected %0b, got %0b", want.ok, res_ch.ok);
                        mismatch_count++;
                    end
                    if (res_ch.key_out !== want.key_out)
                    begin
                        $error("key_out: expected %h, got %h", want.key_out, res_ch.key_out);
                        mismatch_count++;
                    end
                    if (res_ch.value_out !== want.value_out)
                    begin
                        $error("value_out: expected %h, got %h",
                               want.value_out, res_ch.value_out);
                        mismatch_count++;
                    end
                    if (res_ch.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, res_ch.count);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // operation driver, with a random gap after each accepted word
    always @(negedge clk)
    begin
        logic      next_valid;
        table_op_t op;
        if (rst_n)
        begin
            if (op_taken)
            begin
                if (words_taken % 50 == 0)
                    send_calm = ($urandom_range(0, 3) == 0);
                send_wait = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            next_valid = op_ch.valid && !op_taken;
            if (!next_valid)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (op_queue.size() > 0)
                begin
                    op = op_queue.pop_front();
                    op_ch.mode  <= op.mode;
                    op_ch.key   <= op.key;
                    op_ch.value <= op.value;
                    op_ch.index <= op.index;
                    next_valid  = 1'b1;
                end
            end
            op_ch.valid <= next_valid;
        end
    end

    // result receiver, stalling a random number of cycles on each word
    always @(negedge clk)
    begin
        logic stalled;
        if (rst_n)
        begin
            if (result_taken)
            begin
                if (words_checked % 50 == 0)
                    recv_calm = ($urandom_range(0, 3) == 0);
                recv_wait = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            stalled = hold_off || (recv_wait > 0);
            if (recv_wait > 0 && res_ch.valid)
                recv_wait--;
            res_ch.ready <= !stalled;
        end
    end

    // one long receiver hold-off so the table backs up into the input
    initial
    begin
        hold_off = 1'b0;
        while (words_taken < HOLD_START)
            @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_off <= 1'b0;
    end

    function automatic logic [MODE_W-1:0] draw_mode(input int grow_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < grow_pct)
            return ($urandom_range(0, 1) == 1) ? MODE_INSERT : MODE_UPSERT;
        r = $urandom_range(0, 99);
        if (r < 20)
            return MODE_UPDATE;
        if (r < 45)
            return MODE_ERASE;
        if (r < 68)
            return MODE_LOOKUP;
        if (r < 95)
            return MODE_READ_INDEX;
        return ($urandom_range(0, 1) == 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
    endfunction

    // mostly keys already seen, now and then a fresh one
    function automatic logic [KEY_W-1:0] pick_key(input int fresh_pct);
        logic [KEY_W-1:0] k;
        if (key_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct)
        begin
            k = $urandom;
            key_pool.push_back(k);
        end
        else
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        return k;
    endfunction

    task automatic push_op(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value, input logic [ADDR_W-1:0] index);
        table_op_t op;
        op.mode  = mode;
        op.key   = key;
        op.value = value;
        op.index = index;
        op_queue.push_back(op);
    endtask

    // block is idle once every queued word is in and every result is out
    task automatic wait_table_idle();
        while (op_queue.size() != 0 || op_ch.valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(negedge clk);
        cfg_we    <= 1'b0;
        limit_writes++;
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n_ops,
                             input int grow_pct, input int fresh_pct, input int pool_size);
        logic [ADDR_W-1:0] idx;
        wait_table_idle();
        write_limit(lim);
        if (pool_size > 0)
        begin
            key_pool.delete();
            repeat (pool_size) key_pool.push_back($urandom);
        end
        repeat (n_ops)
        begin
            if ($urandom_range(0, 1) == 1)
                idx = ADDR_W'($urandom_range(0, 7));
            else
                idx = ADDR_W'($urandom_range(0, CAPACITY - 1));
            push_op(draw_mode(grow_pct), pick_key(fresh_pct), $urandom, idx);
        end
    endtask

    // reset, stimulus and end of run
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        op_ch.valid   = 1'b0;
        op_ch.mode    = MODE_INSERT;
        op_ch.key     = '0;
        op_ch.value   = '0;
        op_ch.index   = '0;
        res_ch.ready  = 1'b0;
        foreach (ops_by_mode[m])
            ops_by_mode[m] = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: small limit so full and limit cases come quickly
        write_limit(LIMIT_W'(4));
        push_op(MODE_LOOKUP,     32'h0000_0000, 32'h0000_0000, 8'd0);
        push_op(MODE_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 8'd0);
        push_op(MODE_ERASE,      32'h0000_0000, 32'h0000_0000, 8'd0);
        push_op(MODE_UPDATE,     32'h0000_0000, 32'h1111_1111, 8'd0);
        push_op(MODE_INSERT,     32'h0000_0000, 32'h0000_0000, 8'd0);
        push_op(MODE_INSERT,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
        push_op(MODE_INSERT,     32'h0000_0000, 32'h0000_1234, 8'd0);
        push_op(MODE_UPDATE,     32'h0000_0000, 32'hA5A5_A5A5, 8'd0);
        push_op(MODE_UPSERT,     32'hFFFF_FFFF, 32'h5A5A_5A5A, 8'd0);
        push_op(MODE_UPSERT,     32'h1357_9BDF, 32'h2468_ACE0, 8'd0);
        push_op(MODE_INSERT,     32'h8000_0001, 32'h7FFF_FFFE, 8'd0);
        push_op(MODE_INSERT,     32'h0000_0002, 32'h0000_0003, 8'd0);
        push_op(MODE_UPSERT,     32'h0000_0002, 32'h0000_0004, 8'd0);
        push_op(MODE_UPSERT,     32'h0000_0000, 32'hFFFF_FFFF, 8'd0);
        push_op(MODE_LOOKUP,     32'hFFFF_FFFF, 32'h0000_0000, 8'd0);
        push_op(MODE_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 8'd3);
        push_op(MODE_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 8'd4);
        push_op(MODE_READ_INDEX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
        push_op(MODE_ERASE,      32'hFFFF_FFFF, 32'h0000_0000, 8'd0);
        push_op(MODE_ERASE,      32'h8000_0001, 32'h0000_0000, 8'd0);
        push_op(MODE_ERASE,      32'h0000_0000, 32'h0000_0000, 8'd0);
        push_op(MODE_LOOKUP,     32'h1357_9BDF, 32'h0000_0000, 8'd0);
        push_op(MODE_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 8'd0);
        push_op(MODE_SPARE_LO,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
        push_op(MODE_SPARE_HI,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);

        // random phases: limit, words, grow %, fresh key %, new pool size
        run_phase(LIMIT_W'(256), 600, 35, 5, 24);
        run_phase(LIMIT_W'(0),    80, 30, 10, 0);
        run_phase(LIMIT_W'(1),   100, 30, 10, 0);
        run_phase(LIMIT_W'(511), 320, 85, 90, 0);
        run_phase(LIMIT_W'(2),   150, 20, 5, 0);
        run_phase(LIMIT_W'(300), 250, 30, 5, 32);

        wait_table_idle();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("ran %0d table operations: ins %0d upd %0d ups %0d era %0d look %0d rd %0d spare %0d",
                 words_taken, ops_by_mode[MODE_INSERT], ops_by_mode[MODE_UPDATE],
                 ops_by_mode[MODE_UPSERT], ops_by_mode[MODE_ERASE], ops_by_mode[MODE_LOOKUP],
                 ops_by_mode[MODE_READ_INDEX],
                 ops_by_mode[MODE_SPARE_LO] + ops_by_mode[MODE_SPARE_HI]);
        $display("checked %0d result words, table peaked at %0d entries over %0d limit settings",
                 words_checked, peak_entries, limit_writes);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/lkvt_pkg.sv
hdl/lkvt_in_if.sv
hdl/lkvt_out_if.sv
hdl/lkvt_mem.sv
hdl/linear_key_value_table.sv
tb/sv/tb_linear_key_value_table.sv
